// ===== rtl/core/tcpx_pkg.sv =====
// Shared types and constants for the colour-table pixel expander.
package tcpx_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_DIMENSION     = 1023;
  localparam int DIM_W             = $clog2(MAX_DIMENSION + 1);
  localparam int CFG_W             = 10;
  localparam int SLOT_W            = 8;
  localparam int WORD_W            = 16;
  localparam int PIXEL_W           = 24;

  typedef enum logic [1:0] {
    MODE_NIBBLE   = 2'd0,
    MODE_BYTE     = 2'd1,
    MODE_DIRECT15 = 2'd2,
    MODE_DIRECT24 = 2'd3
  } depth_mode_t;

  typedef enum logic [1:0] {
    REG_DEPTH_MODE   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_IMAGE   = 1'b1
  } operation_t;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               row_end;
    logic               frame_end;
    logic               last_of_item;
  } pixel_t;

endpackage

// ===== rtl/core/tcpx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tcpx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tim_clut_pixel_expander.sv =====
// Top level of the colour-table pixel expander.
// Each accepted item either writes one colour table entry or delivers one image halfword,
// and pixels leave one per cycle while the output is not stalled. An item holds the
// sequencer until it has issued its pixels: four in 4-bit mode, two in 8-bit mode, one in
// 15-bit mode, two for the third halfword of a 24-bit triplet, fewer when a row ends inside
// the item, none for a palette write or the first two halfwords of a triplet. The single
// read port of the colour table sets that pace, one lookup per cycle while the queue has
// room. Issued pixels pass the lookup stage registers into a two-entry output queue that
// holds them while the output stalls; the sequencer waits only if the queue would overflow.
module tim_clut_pixel_expander
  import tcpx_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [1:0]         register_index,
  input  logic [CFG_W-1:0]   write_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               operation,
  input  logic [SLOT_W-1:0]  palette_slot,
  input  logic [WORD_W-1:0]  data_word,
  output logic               pixel_valid,
  input  logic               pixel_stall,
  output logic [PIXEL_W-1:0] pixel_value,
  output logic               row_end,
  output logic               frame_end,
  output logic               last_of_item
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  // Configuration registers.
  depth_mode_t      depth_mode;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  // Item being expanded.
  logic              work_valid;
  operation_t        work_op;
  logic [SLOT_W-1:0] work_slot;
  logic [WORD_W-1:0] work_word;
  logic [1:0]        pix_idx;

  phase_t            phase;
  logic [WORD_W-1:0] held_lo;
  logic [WORD_W-1:0] held_hi;
  logic [DIM_W-1:0]  column_count;
  logic [DIM_W-1:0]  row_count;

  // Lookup stage.
  logic               s1_valid;
  logic               s1_lookup;
  logic               s1_inrange;
  logic [PIXEL_W-1:0] s1_direct;
  logic               s1_re;
  logic               s1_fe;
  logic               s1_last;
  logic [WORD_W-1:0]  rd_data;

  // Output queue.
  pixel_t     fifo_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fifo_cnt;

  logic               accept;
  logic               pop;
  logic               gather;
  logic               is_pixel;
  logic               issue_ok;
  logic               fire;
  logic               pix_last;
  logic               work_done;
  logic               re;
  logic               fe;
  logic [1:0]         n_last;
  logic               lookup;
  logic [SLOT_W-1:0]  raw_index;
  logic               raw_inrange;
  logic [PIXEL_W-1:0] direct_value;
  logic [DIM_W-1:0]   last_col;
  logic [DIM_W-1:0]   last_row;
  logic [1:0]         occ_after;
  logic               ram_wr_en;
  pixel_t             s1_pixel;

  assign pop    = pixel_valid && !pixel_stall;
  assign gather = (work_op == OP_IMAGE) && (depth_mode == MODE_DIRECT24)
                  && (phase != PHASE_THIRD);
  assign is_pixel = work_valid && (work_op == OP_IMAGE) && !gather;

  // Only issue when the queue is sure to have room for the pixel in flight.
  assign occ_after = fifo_cnt + 2'(s1_valid) - 2'(pop);
  assign issue_ok  = occ_after < 2'd2;
  assign fire      = is_pixel && issue_ok;

  // A size register of zero wraps to the largest last index.
  assign last_col = image_width - 1'b1;
  assign last_row = image_height - 1'b1;
  assign re       = column_count >= last_col;
  assign fe       = re && (row_count >= last_row);

  always_comb begin
    n_last       = 2'd0;
    lookup       = 1'b0;
    raw_index    = '0;
    direct_value = '0;
    unique case (depth_mode)
      MODE_NIBBLE: begin
        n_last    = 2'd3;
        lookup    = 1'b1;
        raw_index = SLOT_W'(work_word[pix_idx*4 +: 4]);
      end
      MODE_BYTE: begin
        n_last    = 2'd1;
        lookup    = 1'b1;
        raw_index = work_word[pix_idx[0]*8 +: 8];
      end
      MODE_DIRECT15: begin
        n_last       = 2'd0;
        direct_value = PIXEL_W'(work_word);
      end
      MODE_DIRECT24: begin
        n_last = 2'd1;
        if (pix_idx == 2'd0) begin
          direct_value = {held_lo[7:0], held_lo[15:8], held_hi[7:0]};
        end else begin
          direct_value = {held_hi[15:8], work_word[7:0], work_word[15:8]};
        end
      end
      default: begin
        n_last = 2'd0;
      end
    endcase
  end

  assign raw_inrange = {1'b0, raw_index} < (SLOT_W + 1)'(TABLE_ENTRIES);
  assign pix_last    = re || (pix_idx == n_last);
  assign work_done   = work_valid && (!is_pixel || (fire && pix_last));
  assign item_stall  = work_valid && !work_done;
  assign accept      = item_valid && !item_stall;

  assign ram_wr_en = work_valid && (work_op == OP_PALETTE)
                     && ({1'b0, work_slot} < (SLOT_W + 1)'(TABLE_ENTRIES));

  tcpx_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_colour_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(work_slot[IDX_W-1:0]),
    .wr_data(work_word),
    .rd_en  (fire && lookup),
    .rd_addr(raw_index[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode   <= MODE_DIRECT15;
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
    end else if (write_enable) begin
      unique case (reg_index_t'(register_index))
        REG_DEPTH_MODE:   depth_mode   <= depth_mode_t'(write_data[1:0]);
        REG_IMAGE_WIDTH:  image_width  <= write_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= write_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid   <= 1'b0;
      pix_idx      <= 2'd0;
      phase        <= PHASE_FIRST;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (accept) begin
        work_valid <= 1'b1;
        pix_idx    <= 2'd0;
      end else begin
        if (work_done) begin
          work_valid <= 1'b0;
        end
        if (fire) begin
          pix_idx <= pix_idx + 2'd1;
        end
      end
      if (work_done && (work_op == OP_IMAGE)) begin
        if (depth_mode == MODE_DIRECT24) begin
          unique case (phase)
            PHASE_SECOND: phase <= PHASE_THIRD;
            PHASE_THIRD:  phase <= PHASE_FIRST;
            default:      phase <= PHASE_SECOND;
          endcase
        end else begin
          phase <= PHASE_FIRST;
        end
      end
      if (fire) begin
        if (re) begin
          column_count <= '0;
          row_count    <= fe ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_op   <= operation_t'(operation);
      work_slot <= palette_slot;
      work_word <= data_word;
    end
    if (work_done && (work_op == OP_IMAGE) && (depth_mode == MODE_DIRECT24)) begin
      if (phase == PHASE_SECOND) begin
        held_hi <= work_word;
      end else if (phase != PHASE_THIRD) begin
        held_lo <= work_word;
      end
    end
  end

  // Lookup stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_lookup  <= lookup;
      s1_inrange <= raw_inrange;
      s1_direct  <= direct_value;
      s1_re      <= re;
      s1_fe      <= fe;
      s1_last    <= pix_last;
    end
  end

  always_comb begin
    s1_pixel.value        = s1_lookup ? (s1_inrange ? PIXEL_W'(rd_data) : '0) : s1_direct;
    s1_pixel.row_end      = s1_re;
    s1_pixel.frame_end    = s1_fe;
    s1_pixel.last_of_item = s1_last;
  end

  // Output queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fifo_cnt <= fifo_cnt + 2'(s1_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo_mem[wr_ptr] <= s1_pixel;
    end
  end

  assign pixel_valid  = fifo_cnt != 2'd0;
  assign pixel_value  = fifo_mem[rd_ptr].value;
  assign row_end      = fifo_mem[rd_ptr].row_end;
  assign frame_end    = fifo_mem[rd_ptr].frame_end;
  assign last_of_item = fifo_mem[rd_ptr].last_of_item;

endmodule

// ===== rtl/core/tcpx_checker.sv =====
// Port-level checks for the colour-table pixel expander, bound to the top level.
module tcpx_checker
  import tcpx_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               write_enable,
  input logic [1:0]         register_index,
  input logic [CFG_W-1:0]   write_data,
  input logic               item_valid,
  input logic               item_stall,
  input logic               operation,
  input logic [SLOT_W-1:0]  palette_slot,
  input logic [WORD_W-1:0]  data_word,
  input logic               pixel_valid,
  input logic               pixel_stall,
  input logic [PIXEL_W-1:0] pixel_value,
  input logic               row_end,
  input logic               frame_end,
  input logic               last_of_item
);

  logic [1:0] run;
  logic       pixel_taken;

  assign pixel_taken = pixel_valid && !pixel_stall;

  // Pixels delivered since the last one that closed an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 2'd0;
    end else if (pixel_taken) begin
      run <= last_of_item ? 2'd0 : run + 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_value)
      && $stable(row_end) && $stable(frame_end) && $stable(last_of_item))
    else $error("stalled pixel changed or vanished");

  a_frame_in_row: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> !frame_end || row_end)
    else $error("frame end without row end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel shown right after reset");

  a_item_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_taken && !last_of_item |-> run != 2'd3)
    else $error("item gave more than four pixels");

endmodule

bind tim_clut_pixel_expander tcpx_checker u_tcpx_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the colour-table pixel expander.
module testbench;
  import tcpx_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 40000;
  localparam int HOLD_CYCLES = 300;

  class pixel_tracker;
    logic [WORD_W-1:0] colour_lut [256];
    phase_t            gathered;
    logic [31:0]       held_pair;
    logic [DIM_W-1:0]  column;
    logic [DIM_W-1:0]  row;
    depth_mode_t       mode;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    pixel_t            pixels_due [$];
    int                errors;

    function new();
      gathered  = PHASE_FIRST;
      held_pair = '0;
      column    = '0;
      row       = '0;
      mode      = MODE_DIRECT15;
      width     = 10'd1;
      height    = 10'd1;
      errors    = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DEPTH_MODE:   mode = depth_mode_t'(data[1:0]);
        REG_IMAGE_WIDTH:  width = data;
        REG_IMAGE_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    function void note_item(operation_t op, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word);
      logic [PIXEL_W-1:0] pix [4];
      logic [DIM_W-1:0]   last_col;
      logic [DIM_W-1:0]   last_row;
      logic               re;
      logic               fe;
      int                 n;
      if (op == OP_PALETTE) begin
        colour_lut[slot] = word;
        return;
      end
      case (mode)
        MODE_NIBBLE: begin
          gathered = PHASE_FIRST;
          pix[0] = {8'h00, colour_lut[word[3:0]]};
          pix[1] = {8'h00, colour_lut[word[7:4]]};
          pix[2] = {8'h00, colour_lut[word[11:8]]};
          pix[3] = {8'h00, colour_lut[word[15:12]]};
          n = 4;
        end
        MODE_BYTE: begin
          gathered = PHASE_FIRST;
          pix[0] = {8'h00, colour_lut[word[7:0]]};
          pix[1] = {8'h00, colour_lut[word[15:8]]};
          n = 2;
        end
        MODE_DIRECT15: begin
          gathered = PHASE_FIRST;
          pix[0] = {8'h00, word};
          n = 1;
        end
        default: begin
          if (gathered == PHASE_SECOND) begin
            held_pair[31:16] = word;
            gathered = PHASE_THIRD;
            return;
          end
          if (gathered != PHASE_THIRD) begin
            held_pair = {16'h0000, word};
            gathered = PHASE_SECOND;
            return;
          end
          // Three halfwords hold r0 g0 | b0 r1 | g1 b1, low byte first.
          pix[0] = {held_pair[7:0], held_pair[15:8], held_pair[23:16]};
          pix[1] = {held_pair[31:24], word[7:0], word[15:8]};
          gathered = PHASE_FIRST;
          held_pair = '0;
          n = 2;
        end
      endcase
      last_col = (width == 0) ? 10'd1023 : width - 10'd1;
      last_row = (height == 0) ? 10'd1023 : height - 10'd1;
      for (int i = 0; i < n; i++) begin
        re = (column >= last_col);
        fe = re && (row >= last_row);
        pixels_due.push_back(pixel_t'{value: pix[i], row_end: re, frame_end: fe,
                                      last_of_item: re || (i == n - 1)});
        if (re) begin
          // Whatever the item still holds is dropped at the end of a row.
          column = '0;
          row = fe ? '0 : row + 10'd1;
          break;
        end
        column = column + 10'd1;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel: value %h", got.value);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.value !== want.value) begin
        $error("pixel_value: expected %h, got %h", want.value, got.value);
        errors++;
      end
      if (got.row_end !== want.row_end) begin
        $error("row_end: expected %b, got %b", want.row_end, got.row_end);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
        errors++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %b, got %b", want.last_of_item, got.last_of_item);
        errors++;
      end
    endfunction

    function bit done();
      return pixels_due.size() == 0;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               write_enable = 1'b0;
  logic [1:0]         register_index = '0;
  logic [CFG_W-1:0]   write_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               operation = 1'b0;
  logic [SLOT_W-1:0]  palette_slot = '0;
  logic [WORD_W-1:0]  data_word = '0;
  logic               pixel_valid;
  logic               pixel_stall = 1'b0;
  logic [PIXEL_W-1:0] pixel_value;
  logic               row_end;
  logic               frame_end;
  logic               last_of_item;

  pixel_tracker sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  tim_clut_pixel_expander dut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .register_index(register_index), .write_data(write_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .palette_slot(palette_slot), .data_word(data_word),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_value(pixel_value), .row_end(row_end), .frame_end(frame_end),
    .last_of_item(last_of_item)
  );

  always #10 clk = ~clk;

  // Output stall, with an occasional long hold-off requested by the stimulus.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      pixel_stall <= 1'b1;
      hold_left--;
    end else begin
      pixel_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall)
      sb.check_pixel(pixel_t'{value: pixel_value, row_end: row_end, frame_end: frame_end,
                              last_of_item: last_of_item});
  end

  task automatic send_item(operation_t op, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    palette_slot <= slot;
    data_word <= word;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(op, slot, word);
  endtask

  task automatic wait_for_pixels();
    int waited;
    waited = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    while (!sb.done() && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (!sb.done()) begin
      $error("%0d pixels never arrived", sb.pixels_due.size());
      sb.errors++;
      sb.pixels_due.delete();
    end
    // Palette writes and gathered halfwords give no pixel but may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic configure(depth_mode_t mode, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_for_pixels();
    write_reg(REG_DEPTH_MODE, CFG_W'(mode));
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return WORD_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic run_phase(depth_mode_t mode, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                           int count, int profile, bit hold, bit pause);
    configure(mode, w, h);
    case (profile)
      1: begin gap_pct = 88; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 88; end
      3: begin gap_pct = 27; stall_pct = 27; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
    for (int i = 0; i < count; i++) begin
      if (hold && i == count / 4)
        hold_request = 1'b1;
      if (pause && i == count / 2)
        wait_for_pixels();
      if ($urandom_range(9) == 0)
        send_item(OP_PALETTE, SLOT_W'($urandom_range(255)), pick_word());
      else
        send_item(OP_IMAGE, SLOT_W'($urandom_range(255)), pick_word());
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return 10'd1;
      1: return 10'd1023;
      2: return 10'd0;
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every table entry is written before any lookup can reach it.
    for (int s = 0; s < 256; s++)
      send_item(OP_PALETTE, SLOT_W'(s),
                (s == 0) ? 16'h0000 : (s == 255) ? 16'hFFFF : WORD_W'($urandom_range(65535)));

    // Reset settings: each pixel closes the frame.
    send_item(OP_IMAGE, 8'h00, 16'h0000);
    send_item(OP_IMAGE, 8'hFF, 16'hFFFF);
    wait_for_pixels();
    write_reg(REG_SPARE, 10'h3FF);
    send_item(OP_IMAGE, 8'h00, 16'h8001);

    configure(MODE_NIBBLE, 10'd3, 10'd2);
    send_item(OP_IMAGE, 8'h00, 16'hFFFF);
    send_item(OP_IMAGE, 8'h00, 16'h0F0F);
    send_item(OP_IMAGE, 8'h00, 16'h1234);

    configure(MODE_BYTE, 10'd1023, 10'd1023);
    send_item(OP_IMAGE, 8'h00, 16'h00FF);
    send_item(OP_IMAGE, 8'h00, 16'hFF00);

    configure(MODE_DIRECT24, 10'd2, 10'd1);
    send_item(OP_IMAGE, 8'h00, 16'h0000);
    send_item(OP_IMAGE, 8'h00, 16'hFFFF);
    send_item(OP_PALETTE, 8'd7, 16'h7C1F);
    send_item(OP_IMAGE, 8'h00, 16'hA55A);
    send_item(OP_IMAGE, 8'h00, 16'h1234);
    send_item(OP_IMAGE, 8'h00, 16'h5678);
    send_item(OP_IMAGE, 8'h00, 16'h9ABC);

    // A triplet broken off by a mode change starts over.
    send_item(OP_IMAGE, 8'h00, 16'hBEEF);
    configure(MODE_DIRECT15, 10'd2, 10'd1);
    send_item(OP_IMAGE, 8'h00, 16'h4321);
    configure(MODE_DIRECT24, 10'd2, 10'd1);
    send_item(OP_IMAGE, 8'h00, 16'h0102);
    send_item(OP_IMAGE, 8'h00, 16'h0304);
    send_item(OP_IMAGE, 8'h00, 16'h0506);

    // Lowering the height below the row count ends the frame at the next pixel.
    configure(MODE_DIRECT15, 10'd1, 10'd6);
    repeat (4) send_item(OP_IMAGE, 8'h00, pick_word());
    configure(MODE_DIRECT15, 10'd1, 10'd2);
    send_item(OP_IMAGE, 8'h00, 16'h7FFF);

    // Zero size means 1024; then a narrower width ends the long row at once.
    run_phase(MODE_NIBBLE, 10'd0, 10'd0, 20, 0, 1'b0, 1'b0);
    run_phase(MODE_NIBBLE, 10'd4, 10'd3, 8, 3, 1'b0, 1'b0);

    for (int p = 0; p < 10; p++)
      run_phase((p < 8) ? depth_mode_t'(p % 4) : depth_mode_t'($urandom_range(3)),
                pick_size(), pick_size(), $urandom_range(6, 10), p % 4,
                p == 4, p == 6);

    wait_for_pixels();
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tcpx_pkg.sv
rtl/core/tcpx_ram.sv
rtl/core/tim_clut_pixel_expander.sv
rtl/core/tcpx_checker.sv
tb/testbench.sv
